### sv/tlca_pkg.sv
`timescale 1ns / 1ps
package tlca_pkg;

  localparam int NODE_W          = 10;
  localparam int DEPTH_W         = 11;
  localparam int DEPTH_MAX       = 2047;
  localparam int DEF_MAX_NODES   = 1023;
  localparam int DEF_LIFT_LEVELS = 10;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [DEPTH_W-1:0] depth_t;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_BUILD  = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_ANSWER    = 2'd0,
    ST_BUILT     = 2'd1,
    ST_NOT_BUILT = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISP,
    S_ZERO, S_FIXR, S_FIXW, S_LR1, S_LR2, S_LW,
    S_DINIT, S_DR, S_DU, S_DW, S_BFIN,
    S_QA, S_QB, S_QDB, S_QSW, S_QL1, S_QL2, S_QEQ,
    S_QC1, S_QC2, S_QC3, S_QF, S_QFW, S_RES
  } state_t;

  typedef enum logic [4:0] {
    OP_CLEAR, OP_IDLE, OP_DISP,
    OP_ZERO, OP_FIXR, OP_FIXW, OP_LR1, OP_LR2, OP_LW,
    OP_DINIT, OP_DR, OP_DU, OP_DW, OP_BFIN,
    OP_QA, OP_QB, OP_QDB, OP_QSW, OP_QL1, OP_QL2, OP_QEQ,
    OP_QC1, OP_QC2, OP_QC3, OP_QF, OP_QFW, OP_RES
  } dp_op_t;

  typedef struct packed {
    logic in_fire;
    cmd_t cmd;
    logic load_bad;
    logic query_bad;
    logic built;
    logic n_zero;
    logic j_last;
    logic j_clr_last;
    logic lv_top;
    logic lv_last;
    logic lift_take;
    logic a_eq_b;
    logic out_free;
  } dp_status_t;

endpackage

### sv/tlca_if.sv
`timescale 1ns / 1ps
interface tlca_req_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               command;
  logic [tlca_pkg::NODE_W-1:0] first_node;
  logic [tlca_pkg::NODE_W-1:0] second_node;
  modport source (output valid, command, first_node, second_node, input ready);
  modport sink (input valid, command, first_node, second_node, output ready);
endinterface

interface tlca_rsp_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [tlca_pkg::NODE_W-1:0] ancestor;
  modport source (output valid, status, ancestor, input ready);
  modport sink (input valid, status, ancestor, output ready);
endinterface

interface tlca_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [tlca_pkg::NODE_W-1:0] node_count;
  modport source (output valid, node_count, input ready);
  modport sink (input valid, node_count, output ready);
endinterface

### sv/tree_lowest_common_ancestor.sv
`timescale 1ns / 1ps
// a load is written in the cycle after acceptance; a query is longest when every level lifts;
//   a build zeroes node 0 on each level, fixes level 0, fills the upper levels, then finds depths
// throughput: one word at a time, set by the single port of the ancestor table ram
// reset: synchronous, clears control state, then a clearing pass over nodes 0 to MAX_NODES
//   zeroes level 0 of the ancestor table while no word is accepted
module tree_lowest_common_ancestor #(
  parameter int MAX_NODES   = tlca_pkg::DEF_MAX_NODES,
  parameter int LIFT_LEVELS = tlca_pkg::DEF_LIFT_LEVELS
) (
  input logic        clk,
  input logic        rst,
  tlca_req_if.sink   req,
  tlca_rsp_if.source rsp,
  tlca_cfg_if.sink   cfg
);
  import tlca_pkg::*;

  // command from the sequencer, flags back from the datapath
  dp_op_t     op;
  dp_status_t st;

  // sequencer: one state per table access, loops over levels and nodes
  tlca_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .op  (op)
  );

  // datapath: ancestor and depth rams, node and level counters, result register
  tlca_dp #(
    .MAX_NODES   (MAX_NODES),
    .LIFT_LEVELS (LIFT_LEVELS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .op  (op),
    .st  (st),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );
endmodule

### sv/tlca_ram.sv
`timescale 1ns / 1ps
module tlca_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end
endmodule

### sv/tlca_ctrl.sv
`timescale 1ns / 1ps
module tlca_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  tlca_pkg::dp_status_t   st,
  output tlca_pkg::dp_op_t       op
);
  import tlca_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (st.j_clr_last) state_next = S_IDLE;
      S_IDLE:  if (st.in_fire) state_next = S_DISP;
      S_DISP: begin
        case (st.cmd)
          CMD_LOAD:  state_next = st.load_bad ? S_RES : S_IDLE;
          CMD_BUILD: state_next = S_ZERO;
          CMD_QUERY: state_next = (st.query_bad || !st.built) ? S_RES : S_QA;
          default:   state_next = S_IDLE;
        endcase
      end
      S_ZERO: if (st.lv_top) state_next = st.n_zero ? S_BFIN : S_FIXR;
      S_FIXR: state_next = S_FIXW;
      S_FIXW: begin
        if (st.j_last) state_next = st.lv_top ? S_DINIT : S_LR1;
        else state_next = S_FIXR;
      end
      S_LR1:   state_next = S_LR2;
      S_LR2:   state_next = S_LW;
      S_LW:    state_next = (st.j_last && st.lv_top) ? S_DINIT : S_LR1;
      S_DINIT: state_next = S_DR;
      S_DR:    state_next = S_DU;
      S_DU:    state_next = st.lv_last ? S_DW : S_DR;
      S_DW:    state_next = st.j_last ? S_BFIN : S_DINIT;
      S_BFIN:  state_next = S_RES;
      S_QA:    state_next = S_QB;
      S_QB:    state_next = S_QDB;
      S_QDB:   state_next = S_QSW;
      S_QSW:   state_next = S_QL1;
      S_QL1: begin
        if (st.lift_take) state_next = S_QL2;
        else if (st.lv_last) state_next = S_QEQ;
      end
      S_QL2:   state_next = st.lv_last ? S_QEQ : S_QL1;
      S_QEQ:   state_next = st.a_eq_b ? S_RES : S_QC1;
      S_QC1:   state_next = S_QC2;
      S_QC2:   state_next = S_QC3;
      S_QC3:   state_next = st.lv_last ? S_QF : S_QC1;
      S_QF:    state_next = S_QFW;
      S_QFW:   state_next = S_RES;
      S_RES:   if (st.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      S_CLEAR: op = OP_CLEAR;
      S_IDLE:  op = OP_IDLE;
      S_DISP:  op = OP_DISP;
      S_ZERO:  op = OP_ZERO;
      S_FIXR:  op = OP_FIXR;
      S_FIXW:  op = OP_FIXW;
      S_LR1:   op = OP_LR1;
      S_LR2:   op = OP_LR2;
      S_LW:    op = OP_LW;
      S_DINIT: op = OP_DINIT;
      S_DR:    op = OP_DR;
      S_DU:    op = OP_DU;
      S_DW:    op = OP_DW;
      S_BFIN:  op = OP_BFIN;
      S_QA:    op = OP_QA;
      S_QB:    op = OP_QB;
      S_QDB:   op = OP_QDB;
      S_QSW:   op = OP_QSW;
      S_QL1:   op = OP_QL1;
      S_QL2:   op = OP_QL2;
      S_QEQ:   op = OP_QEQ;
      S_QC1:   op = OP_QC1;
      S_QC2:   op = OP_QC2;
      S_QC3:   op = OP_QC3;
      S_QF:    op = OP_QF;
      S_QFW:   op = OP_QFW;
      S_RES:   op = OP_RES;
      default: op = OP_IDLE;
    endcase
  end
endmodule

### sv/tlca_dp.sv
`timescale 1ns / 1ps
module tlca_dp #(
  parameter int MAX_NODES   = tlca_pkg::DEF_MAX_NODES,
  parameter int LIFT_LEVELS = tlca_pkg::DEF_LIFT_LEVELS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tlca_pkg::dp_op_t     op,
  output tlca_pkg::dp_status_t st,
  tlca_req_if.sink             req,
  tlca_rsp_if.source           rsp,
  tlca_cfg_if.sink             cfg
);
  import tlca_pkg::*;

  localparam int NW     = $clog2(MAX_NODES + 1);
  localparam int JW     = (NW > NODE_W) ? NW : NODE_W;
  localparam int LW     = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int CW     = LIFT_LEVELS + 1;
  localparam int ANC_D  = LIFT_LEVELS * (2 ** NW);
  localparam int ANC_AW = $clog2(ANC_D);
  localparam int DEP_D  = 2 ** NW;

  // registers
  node_t         node_count;
  logic          built;
  cmd_t          cmd;
  node_t         a, b, ta;
  depth_t        da, db;
  logic [LW-1:0] lv;
  logic [JW-1:0] j;
  logic [CW-1:0] cnt;
  status_t       res_status;
  node_t         res_anc;

  node_t         n;
  node_t         anc_rd;
  depth_t        dep_rd;
  logic          anc_we, anc_re, dep_we, dep_re;
  logic [LW-1:0] lv_sel;
  logic [NW-1:0] node_sel;
  node_t         anc_wd;
  logic [NW-1:0] dep_addr;
  depth_t        dep_wd;
  depth_t        diff;
  logic [31:0]   step;
  logic          in_fire;

  assign n = (32'(node_count) > MAX_NODES) ? NODE_W'(MAX_NODES) : node_count;
  assign req.ready = (op == OP_IDLE);
  assign in_fire   = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign diff      = da - db;
  assign step      = 32'd1 << lv;

  assign st.in_fire    = in_fire;
  assign st.cmd        = cmd;
  assign st.load_bad   = (a == '0) || (a > n) || (b > n);
  assign st.query_bad  = (a == '0) || (a > n) || (b == '0) || (b > n);
  assign st.built      = built;
  assign st.n_zero     = (n == '0);
  assign st.j_last     = (j == JW'(n));
  assign st.j_clr_last = (j == JW'(MAX_NODES));
  assign st.lv_top     = (lv == LW'(LIFT_LEVELS - 1));
  assign st.lv_last    = (lv == '0);
  assign st.lift_take  = (32'(diff) >= step);
  assign st.a_eq_b     = (a == b);
  assign st.out_free   = !rsp.valid || rsp.ready;

  // table port control
  always_comb begin
    anc_we   = 1'b0;
    anc_re   = 1'b0;
    lv_sel   = '0;
    node_sel = NW'(a);
    anc_wd   = '0;
    dep_we   = 1'b0;
    dep_re   = 1'b0;
    dep_addr = NW'(a);
    dep_wd   = (32'(cnt) > DEPTH_MAX) ? DEPTH_W'(DEPTH_MAX) : DEPTH_W'(cnt);
    case (op)
      OP_CLEAR: begin
        anc_we   = 1'b1;
        node_sel = NW'(j);
      end
      OP_DISP: begin
        anc_we = (cmd == CMD_LOAD) && !st.load_bad;
        anc_wd = b;
      end
      OP_ZERO: begin
        anc_we   = 1'b1;
        lv_sel   = lv;
        node_sel = '0;
      end
      OP_FIXR: begin
        anc_re   = 1'b1;
        node_sel = NW'(j);
      end
      OP_FIXW: begin
        anc_we   = (j == JW'(1)) || (anc_rd > n);
        node_sel = NW'(j);
      end
      OP_LR1: begin
        anc_re   = 1'b1;
        lv_sel   = lv - LW'(1);
        node_sel = NW'(j);
      end
      OP_LR2: begin
        anc_re   = 1'b1;
        lv_sel   = lv - LW'(1);
        node_sel = NW'(anc_rd);
      end
      OP_LW: begin
        anc_we   = 1'b1;
        lv_sel   = lv;
        node_sel = NW'(j);
        anc_wd   = anc_rd;
      end
      OP_DR: begin
        anc_re = 1'b1;
        lv_sel = lv;
      end
      OP_DW: begin
        dep_we   = 1'b1;
        dep_addr = NW'(j);
      end
      OP_QA: dep_re = 1'b1;
      OP_QB: begin
        dep_re   = 1'b1;
        dep_addr = NW'(b);
      end
      OP_QL1: begin
        anc_re = st.lift_take;
        lv_sel = lv;
      end
      OP_QC1: begin
        anc_re = 1'b1;
        lv_sel = lv;
      end
      OP_QC2: begin
        anc_re   = 1'b1;
        lv_sel   = lv;
        node_sel = NW'(b);
      end
      OP_QF: anc_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_W'(1);
      built      <= 1'b0;
      j          <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      // in the result state a taken word is replaced by the new one below
      if (rsp.valid && rsp.ready && (op != OP_RES)) rsp.valid <= 1'b0;
      if (cfg.valid && cfg.ready) begin
        node_count <= cfg.node_count;
        built      <= 1'b0;
      end
      if (in_fire) begin
        cmd <= cmd_t'(req.command);
        a   <= req.first_node;
        b   <= req.second_node;
      end
      case (op)
        OP_CLEAR: j <= j + JW'(1);
        OP_DISP: begin
          j          <= JW'(1);
          lv         <= '0;
          res_anc    <= '0;
          res_status <= (cmd == CMD_QUERY && !st.query_bad) ? ST_NOT_BUILT : ST_RANGE;
          if (cmd == CMD_LOAD && !st.load_bad) built <= 1'b0;
        end
        OP_ZERO: lv <= st.lv_top ? '0 : lv + LW'(1);
        OP_FIXW: begin
          if (st.j_last) begin
            j  <= JW'(1);
            lv <= LW'(1);
          end else begin
            j <= j + JW'(1);
          end
        end
        OP_LW: begin
          if (st.j_last) begin
            j  <= JW'(1);
            lv <= lv + LW'(1);
          end else begin
            j <= j + JW'(1);
          end
        end
        OP_DINIT: begin
          a   <= NODE_W'(j);
          cnt <= CW'(1);
          lv  <= LW'(LIFT_LEVELS - 1);
        end
        OP_DU: begin
          if (anc_rd != '0) begin
            a   <= anc_rd;
            cnt <= cnt + (CW'(1) << lv);
          end
          lv <= lv - LW'(1);
        end
        OP_DW: j <= j + JW'(1);
        OP_BFIN: begin
          built      <= 1'b1;
          res_status <= ST_BUILT;
          res_anc    <= '0;
        end
        OP_QB:  da <= dep_rd;
        OP_QDB: db <= dep_rd;
        OP_QSW: begin
          if (da < db) begin
            a  <= b;
            b  <= a;
            da <= db;
            db <= da;
          end
          lv <= LW'(LIFT_LEVELS - 1);
        end
        OP_QL1: if (!st.lift_take) lv <= lv - LW'(1);
        OP_QL2: begin
          a  <= anc_rd;
          da <= da - DEPTH_W'(step);
          lv <= lv - LW'(1);
        end
        OP_QEQ: begin
          res_status <= ST_ANSWER;
          res_anc    <= a;
          lv         <= LW'(LIFT_LEVELS - 1);
        end
        OP_QC2: ta <= anc_rd;
        OP_QC3: begin
          if (ta != anc_rd) begin
            a <= ta;
            b <= anc_rd;
          end
          lv <= lv - LW'(1);
        end
        OP_QFW: begin
          res_status <= ST_ANSWER;
          res_anc    <= anc_rd;
        end
        OP_RES: begin
          if (st.out_free) begin
            rsp.valid    <= 1'b1;
            rsp.status   <= res_status;
            rsp.ancestor <= res_anc;
          end
        end
        default: ;
      endcase
    end
  end

  tlca_ram #(.WIDTH(NODE_W), .DEPTH(ANC_D)) u_anc_ram (
    .clk     (clk),
    .wr_en   (anc_we),
    .rd_en   (anc_re),
    .addr    (ANC_AW'({lv_sel, node_sel})),
    .wr_data (anc_wd),
    .rd_data (anc_rd)
  );

  tlca_ram #(.WIDTH(DEPTH_W), .DEPTH(DEP_D)) u_dep_ram (
    .clk     (clk),
    .wr_en   (dep_we),
    .rd_en   (dep_re),
    .addr    (dep_addr),
    .wr_data (dep_wd),
    .rd_data (dep_rd)
  );
endmodule

### sv/tlca_checker.sv
`timescale 1ns / 1ps
module tlca_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [1:0] rsp_status,
  input logic [9:0] rsp_ancestor,
  input logic       cfg_ready
);
  import tlca_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_ancestor))
    else $error("response word changed while stalled");

  a_anc_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_ANSWER |-> rsp_ancestor == 10'd0)
    else $error("ancestor not zero on non-answer status");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second word accepted while one is in work");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("config port not ready");
endmodule

bind tree_lowest_common_ancestor tlca_checker u_tlca_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_status   (rsp.status),
  .rsp_ancestor (rsp.ancestor),
  .cfg_ready    (cfg.ready)
);

### tb/tlca_checker.sv
`timescale 1ns / 1ps
module tlca_scoreboard
  import tlca_pkg::*;
(
  input  logic clk,
  input  logic rst,
  tlca_req_if  req,
  tlca_rsp_if  rsp,
  tlca_cfg_if  cfg,
  output int   fail_count,
  output int   pending
);

  localparam int LEVELS = DEF_LIFT_LEVELS;
  localparam int NODES  = DEF_MAX_NODES;

  typedef struct packed {
    status_t status;
    node_t   ancestor;
  } answer_t;

  node_t   jump [LEVELS][NODES+1];
  depth_t  depth [NODES+1];
  logic    built;
  node_t   count;
  answer_t answers [$];

  function automatic int nodes_in_use();
    return (count < NODES) ? int'(count) : NODES;
  endfunction

  // level 0 fixup, then doubling, then depth by lifting to the sentinel
  function automatic void build_jumps(int n);
    int x;
    int y;
    int cnt;
    jump[0][0] = '0;
    if (n >= 1) jump[0][1] = '0;
    for (int j = 2; j <= n; j++)
      if (jump[0][j] > n) jump[0][j] = '0;
    for (int lv = 1; lv < LEVELS; lv++) begin
      jump[lv][0] = '0;
      for (int j = 1; j <= n; j++) jump[lv][j] = jump[lv-1][jump[lv-1][j]];
    end
    for (int j = 1; j <= n; j++) begin
      x   = j;
      cnt = 1;
      for (int lv = LEVELS - 1; lv >= 0; lv--) begin
        y = jump[lv][x];
        if (y != 0) begin
          x   = y;
          cnt += 1 << lv;
        end
      end
      depth[j] = (cnt > DEPTH_MAX) ? depth_t'(DEPTH_MAX) : depth_t'(cnt);
    end
  endfunction

  function automatic node_t meet(int a, int b);
    int da;
    int db;
    int t;
    da = depth[a];
    db = depth[b];
    if (da < db) begin
      t = a;  a = b;   b = t;
      t = da; da = db; db = t;
    end
    for (int lv = LEVELS - 1; lv >= 0; lv--)
      if (da - db >= (1 << lv)) begin
        a  = jump[lv][a];
        da -= 1 << lv;
      end
    if (a == b) return node_t'(a);
    for (int lv = LEVELS - 1; lv >= 0; lv--)
      if (jump[lv][a] != jump[lv][b]) begin
        a = jump[lv][a];
        b = jump[lv][b];
      end
    return jump[0][a];
  endfunction

  function automatic void expect_word(status_t s, node_t anc);
    answers.insert(answers.size(), answer_t'{s, anc});
  endfunction

  function automatic void predict(cmd_t c, int a, int b);
    int n;
    n = nodes_in_use();
    case (c)
      CMD_LOAD: begin
        if (a < 1 || a > n || b > n) expect_word(ST_RANGE, '0);
        else begin
          jump[0][a] = node_t'(b);
          built = 1'b0;
        end
      end
      CMD_BUILD: begin
        build_jumps(n);
        built = 1'b1;
        expect_word(ST_BUILT, '0);
      end
      CMD_QUERY: begin
        if (a < 1 || a > n || b < 1 || b > n) expect_word(ST_RANGE, '0);
        else if (!built) expect_word(ST_NOT_BUILT, '0);
        else expect_word(ST_ANSWER, meet(a, b));
      end
      default: ;
    endcase
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      for (int lv = 0; lv < LEVELS; lv++)
        for (int j = 0; j <= NODES; j++) jump[lv][j] = '0;
      for (int j = 0; j <= NODES; j++) depth[j] = '0;
      built = 1'b0;
      count = node_t'(1);
      answers.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        count = cfg.node_count;
        built = 1'b0;
      end
      if (req.valid && req.ready)
        predict(cmd_t'(req.command), int'(req.first_node), int'(req.second_node));
      if (rsp.valid && rsp.ready) begin
        if (answers.size() == 0) begin
          $error("unexpected word: status %0d ancestor %0d", rsp.status, rsp.ancestor);
          fail_count++;
        end else begin
          want = answers.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            fail_count++;
          end
          if (rsp.ancestor !== want.ancestor) begin
            $error("ancestor: expected %0d, got %0d", want.ancestor, rsp.ancestor);
            fail_count++;
          end
        end
      end
    end
    pending = answers.size();
  end

endmodule

### tb/tree_lowest_common_ancestor_tb.sv
`timescale 1ns / 1ps
module tree_lowest_common_ancestor_tb;
  import tlca_pkg::*;

  // generous: two full-size builds plus a long random run with stalls
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int TARGET      = 1600;
  // cycles to let a resultless load finish before touching the register
  localparam int DRAIN       = 60;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   cycles;
  int   sent;
  int   stall;

  tlca_req_if req_ch ();
  tlca_rsp_if rsp_ch ();
  tlca_cfg_if cfg_ch ();

  tree_lowest_common_ancestor DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  tlca_scoreboard u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg        (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tree_lowest_common_ancestor_tb: FAIL");
      $finish;
    end
  end

  // mostly no gap, often a short one, now and then a long one
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall        <= 0;
    end else if (stall > 0) begin
      rsp_ch.ready <= 1'b0;
      stall        <= stall - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      stall        <= pause_len();
    end
  end

  // one word on the request channel; valid stays up when no gap follows
  task automatic send_word(cmd_t c, int a, int b);
    int gap;
    req_ch.valid       <= 1'b1;
    req_ch.command     <= c;
    req_ch.first_node  <= node_t'(a);
    req_ch.second_node <= node_t'(b);
    do @(posedge clk); while (!req_ch.ready);
    sent++;
    gap = pause_len();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid, wait for every expected word, then let a trailing load finish
  task automatic settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_count(int v);
    settle();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.node_count <= node_t'(v);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // random labeling with root 1; every node hangs under an earlier one
  task automatic grow_tree(int n);
    int order [$];
    int pick [$];
    order.insert(0, 1);
    for (int k = 2; k <= n; k++) order.insert($urandom_range(1, order.size()), k);
    for (int i = 1; i < n; i++) pick.insert(pick.size(), i);
    pick.shuffle();
    foreach (pick[i])
      send_word(CMD_LOAD, order[pick[i]], order[$urandom_range(0, pick[i] - 1)]);
  endtask

  // mostly good queries, with range errors, unused words, stray loads, rebuilds
  task automatic query_burst(int n, int total);
    int r;
    for (int i = 0; i < total; i++) begin
      r = $urandom_range(0, 99);
      if (r < 80)
        send_word(CMD_QUERY, $urandom_range(1, n), $urandom_range(1, n));
      else if (r < 88)
        send_word(CMD_QUERY, $urandom_range(0, 1023), $urandom_range(0, 1023));
      else if (r < 91)
        send_word(CMD_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023));
      else if (r < 94)
        send_word(CMD_LOAD, $urandom_range(0, 1023), $urandom_range(0, 1023));
      else if (r < 97)
        // may close a cycle or cut a chain
        send_word(CMD_LOAD, $urandom_range(1, n), $urandom_range(0, n));
      else
        send_word(CMD_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023));
    end
  endtask

  initial begin
    int n;
    int phase;
    rst                = 1'b1;
    cycles             = 0;
    sent               = 0;
    req_ch.valid       = 1'b0;
    req_ch.command     = CMD_LOAD;
    req_ch.first_node  = '0;
    req_ch.second_node = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.node_count  = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset count of one: unbuilt query, range checks, root self-parent
    send_word(CMD_QUERY, 1, 1);
    send_word(CMD_LOAD, 0, 0);
    send_word(CMD_LOAD, 1, 2);
    send_word(CMD_LOAD, 1, 1);
    send_word(CMD_BUILD, 0, 0);
    send_word(CMD_QUERY, 1, 1);
    send_word(CMD_QUERY, 0, 1);
    send_word(CMD_UNUSED, 1023, 1023);

    // zero nodes: build still reports built, query and load are out of range
    write_count(0);
    send_word(CMD_BUILD, 0, 0);
    send_word(CMD_QUERY, 1, 1);
    send_word(CMD_LOAD, 1, 0);

    // full size: extreme labels, loaded root parent is ignored
    write_count(1023);
    send_word(CMD_LOAD, 1023, 1);
    send_word(CMD_LOAD, 512, 1023);
    send_word(CMD_LOAD, 1, 5);
    send_word(CMD_BUILD, 0, 0);
    send_word(CMD_QUERY, 1023, 512);
    send_word(CMD_QUERY, 512, 512);
    send_word(CMD_QUERY, 1023, 0);

    // stale parent above a shrunken count, and a write clearing the built flag
    write_count(20);
    send_word(CMD_LOAD, 5, 15);
    send_word(CMD_LOAD, 6, 5);
    send_word(CMD_BUILD, 0, 0);
    write_count(10);
    send_word(CMD_QUERY, 6, 1);
    send_word(CMD_BUILD, 0, 0);
    send_word(CMD_QUERY, 6, 5);

    // random trees; one full-size phase along the way
    phase = 0;
    while (sent < TARGET) begin
      if (phase == 3) n = 1023;
      else if ($urandom_range(0, 9) == 0) n = $urandom_range(1, 2);
      else n = $urandom_range(3, 40);
      write_count(n);
      grow_tree(n);
      send_word(CMD_BUILD, 0, 0);
      query_burst(n, 40);
      phase++;
    end

    settle();
    if (fail_count == 0) begin
      $display("tree_lowest_common_ancestor_tb: PASS");
    end else begin
      $display("tree_lowest_common_ancestor_tb: FAIL");
    end
    $finish;
  end

endmodule
